[design/pip_pkg.sv]
// package for the point-in-polygon test block
// sizes, derived widths and sequencer state type; no dependencies
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 8;
    localparam int COORD_WIDTH  = 16;

    localparam int IDX_W    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W    = IDX_W + 1;
    localparam int SLOT_W   = 3;
    localparam int CFG_W    = 4;
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 3;

    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic OP_LOAD          = 1'b0;
    localparam logic OP_QUERY         = 1'b1;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = CFG_W'(6);

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]      diff_t;
    typedef logic signed [PROD_W-1:0]      prod_t;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_MUL_L  = 6'b000100,
        S_MUL_R  = 6'b001000,
        S_CMP    = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

endpackage

`default_nettype wire

[design/pip_if.sv]
// valid/ready channel interfaces for query items and results
// depends on pip_pkg
`default_nettype none

interface pip_in_if;
    import pip_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [SLOT_W-1:0]  vertex_index;
    coord_t             coord_x;
    coord_t             coord_y;

    modport source (output valid, output op, output vertex_index, output coord_x,
                    output coord_y, input ready);
    modport sink   (input valid, input op, input vertex_index, input coord_x,
                    input coord_y, output ready);
endinterface

interface pip_out_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

[design/point_in_polygon_test_top.sv]
// even-odd ray-casting point-in-polygon test, top level
// depends on pip_pkg and pip_if (pip_in_if, pip_out_if)
`default_nettype none

// A load transfer (op 0) writes one vertex into the table and gives no result;
// a query transfer (op 1) gives one inside_res transfer. A query walks the
// polygon one edge at a time through one shared 17x17 multiplier: each edge
// goes through a table read, two products and a compare, and item ready stays
// low from accept until the result is registered. The result sits in an output
// register, so the next item is taken while a result still waits. The user must
// write vertex_count (address 0) over the APB port only while the block is idle;
// the block does not enforce this. Counts above the table size use the table
// size, and counts below three give 0. Vertices must be loaded before a query
// reads them.
module point_in_polygon_test_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [pip_pkg::PADDR_W-1:0] paddr,
    input  wire logic [pip_pkg::PDATA_W-1:0] pwdata,
    output logic      [pip_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    pip_in_if.sink                       item,
    pip_out_if.source                    result
);
    import pip_pkg::*;

    // configuration
    logic [CFG_W-1:0] vertex_count_reg;
    logic             cfg_write;

    // sequencer
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] edge_reg, edge_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             flag_reg, flag_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_res_reg, out_res_next;
    coord_t           px_reg, px_next;
    coord_t           py_reg, py_next;
    prod_t            prod_l_reg, prod_l_next;
    prod_t            prod_r_reg, prod_r_next;

    // vertex table
    coord_t           vx_mem [MAX_VERTICES];
    coord_t           vy_mem [MAX_VERTICES];
    coord_t           xi_reg, xj_reg, yi_reg, yj_reg;
    logic [IDX_W-1:0] idx_j;
    logic             item_xfer;
    logic             load_en;

    // shared multiplier
    diff_t            mul_a, mul_b;
    prod_t            mul_p;
    diff_t            dy;
    logic             straddle;
    logic             left;
    logic             last_edge;
    logic [CNT_W-1:0] count_clamped;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_VERTEX_COUNT)
        begin
            prdata = PDATA_W'(vertex_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= VERTEX_COUNT_RESET;
        end
        else if (cfg_write && paddr[2] == REG_VERTEX_COUNT)
        begin
            vertex_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign item.ready    = (state_reg == S_IDLE);
    assign item_xfer     = item.valid && item.ready;
    assign load_en       = item_xfer && item.op == OP_LOAD
                           && int'(item.vertex_index) < MAX_VERTICES;
    assign result.valid      = out_valid_reg;
    assign result.inside_res = out_res_reg;

    assign idx_j = (edge_reg == '0) ? IDX_W'(count_reg - CNT_W'(1)) : edge_reg - IDX_W'(1);

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            vx_mem[IDX_W'(item.vertex_index)] <= item.coord_x;
            vy_mem[IDX_W'(item.vertex_index)] <= item.coord_y;
        end
        xi_reg <= vx_mem[edge_reg];
        yi_reg <= vy_mem[edge_reg];
        xj_reg <= vx_mem[idx_j];
        yj_reg <= vy_mem[idx_j];
    end

    always_comb
    begin
        if (int'(vertex_count_reg) > MAX_VERTICES)
        begin
            count_clamped = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            count_clamped = CNT_W'(vertex_count_reg);
        end
    end

    assign dy = {yj_reg[COORD_WIDTH-1], yj_reg} - {yi_reg[COORD_WIDTH-1], yi_reg};

    always_comb
    begin
        if (state_reg == S_MUL_L)
        begin
            mul_a = {px_reg[COORD_WIDTH-1], px_reg} - {xi_reg[COORD_WIDTH-1], xi_reg};
            mul_b = dy;
        end
        else
        begin
            mul_a = {xj_reg[COORD_WIDTH-1], xj_reg} - {xi_reg[COORD_WIDTH-1], xi_reg};
            mul_b = {py_reg[COORD_WIDTH-1], py_reg} - {yi_reg[COORD_WIDTH-1], yi_reg};
        end
    end

    assign mul_p     = mul_a * mul_b;
    assign straddle  = (yi_reg > py_reg) != (yj_reg > py_reg);
    assign left      = dy[DIFF_W-1] ? (prod_r_reg < prod_l_reg) : (prod_l_reg < prod_r_reg);
    assign last_edge = (CNT_W'(edge_reg) == count_reg - CNT_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        edge_next      = edge_reg;
        count_next     = count_reg;
        flag_next      = flag_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_xfer && item.op == OP_QUERY)
                begin
                    px_next    = item.coord_x;
                    py_next    = item.coord_y;
                    count_next = count_clamped;
                    edge_next  = '0;
                    flag_next  = 1'b0;
                    if (count_clamped == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_MUL_L;
            end
            S_MUL_L:
            begin
                prod_l_next = mul_p;
                state_next  = S_MUL_R;
            end
            S_MUL_R:
            begin
                prod_r_next = mul_p;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                if (straddle && left)
                begin
                    flag_next = !flag_reg;
                end
                if (last_edge)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    edge_next  = edge_reg + IDX_W'(1);
                    state_next = S_READ;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_res_next   = flag_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg    <= edge_next;
        count_reg   <= count_next;
        flag_reg    <= flag_next;
        out_res_reg <= out_res_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        prod_l_reg  <= prod_l_next;
        prod_r_reg  <= prod_r_next;
    end

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the point-in-polygon block: vertex loads, queries
// and vertex_count writes, with random idling on both channels
// depends on pip_pkg, pip_if and point_in_polygon_test_top
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam int GAP_MAX      = 13;
    localparam int DRAIN_CYCLES = 4 * MAX_VERTICES + 8;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 130;
    localparam int COORD_MAX_I  = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int COORD_MIN_I  = -(2 ** (COORD_WIDTH - 1));

    localparam coord_t C_MAX = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
    localparam coord_t C_MIN = {1'b1, {(COORD_WIDTH - 1){1'b0}}};

    localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = PADDR_W'(4 * int'(REG_VERTEX_COUNT));

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    pip_in_if  item_ch ();
    pip_out_if result_ch ();

    point_in_polygon_test_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    coord_t            vx_table [MAX_VERTICES];
    coord_t            vy_table [MAX_VERTICES];
    logic [CFG_W-1:0]  count_reg;
    bit                inside_expected [$];
    int                mismatch_count;
    bit                src_steady;
    bit                sink_steady;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : int'($urandom_range(0, GAP_MAX));
    endfunction

    function automatic coord_t clamp_coord(input int v);
        if (v > COORD_MAX_I)
            return C_MAX;
        if (v < COORD_MIN_I)
            return C_MIN;
        return coord_t'(v);
    endfunction

    function automatic coord_t draw_coord(input int center, input int span);
        case ($urandom_range(0, 15))
            0: return C_MIN;
            1: return C_MAX;
            2: return coord_t'($urandom);
            default: return clamp_coord(center + int'($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // even-odd crossing count, division replaced by sign-aware cross products
    function automatic bit predict_inside(input coord_t px, input coord_t py);
        int     n;
        int     i;
        int     j;
        longint dy;
        longint lhs;
        longint rhs;
        bit     flag;
        bit     left;
        flag = 1'b0;
        n = (count_reg > MAX_VERTICES) ? MAX_VERTICES : int'(count_reg);
        for (i = 0; i < n; i++)
        begin
            j = (i == 0) ? n - 1 : i - 1;
            if ((vy_table[i] > py) != (vy_table[j] > py))
            begin
                dy   = longint'(vy_table[j]) - longint'(vy_table[i]);
                lhs  = (longint'(px) - longint'(vx_table[i])) * dy;
                rhs  = (longint'(vx_table[j]) - longint'(vx_table[i])) *
                       (longint'(py) - longint'(vy_table[i]));
                left = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
                if (left)
                    flag = ~flag;
            end
        end
        return flag;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    task automatic send_item(input logic op, input logic [SLOT_W-1:0] slot,
                             input coord_t x, input coord_t y);
        int gap;
        if ($urandom_range(0, 63) == 0)
            src_steady = ~src_steady;
        gap = draw_wait(src_steady);
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.vertex_index <= slot;
        item_ch.coord_x      <= x;
        item_ch.coord_y      <= y;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
        if (op == OP_LOAD)
        begin
            vx_table[slot] = x;
            vy_table[slot] = y;
        end
        else
            inside_expected.push_back(predict_inside(x, y));
    endtask

    task automatic wait_idle;
        item_ch.valid <= 1'b0;
        while (inside_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_vertex_count;
        logic [PDATA_W-1:0] got;
        reg_read(ADDR_VERTEX_COUNT, got);
        if (got !== PDATA_W'(count_reg))
            report_mismatch("vertex_count readback", longint'(count_reg), longint'(got));
    endtask

    // upper data bits are random and must be dropped by the register
    task automatic set_vertex_count(input logic [CFG_W-1:0] value);
        logic [PDATA_W-1:0] data;
        data = ($urandom << CFG_W) | PDATA_W'(value);
        reg_write(ADDR_VERTEX_COUNT, data);
        count_reg = value;
        check_vertex_count();
    endtask

    task automatic test_reset_value;
        count_reg = VERTEX_COUNT_RESET;
        check_vertex_count();
    endtask

    // concave outline with corners on the coordinate extremes, six vertices in use
    task automatic test_directed_polygon;
        send_item(OP_LOAD, SLOT_W'(0), C_MIN, C_MIN);
        send_item(OP_LOAD, SLOT_W'(1), C_MAX, C_MIN);
        send_item(OP_LOAD, SLOT_W'(2), C_MAX, C_MAX);
        send_item(OP_LOAD, SLOT_W'(3), coord_t'(0), coord_t'(0));
        send_item(OP_LOAD, SLOT_W'(4), C_MIN, C_MAX);
        send_item(OP_LOAD, SLOT_W'(5), C_MIN, coord_t'(0));
        send_item(OP_LOAD, SLOT_W'(6), coord_t'(100), coord_t'(-200));
        send_item(OP_LOAD, SLOT_W'(7), coord_t'(-100), coord_t'(200));
        send_item(OP_QUERY, SLOT_W'(7), coord_t'(0), coord_t'(-16));
        send_item(OP_QUERY, SLOT_W'(0), coord_t'(0), coord_t'(16));
        send_item(OP_QUERY, SLOT_W'(5), coord_t'(-1), coord_t'(0));
        send_item(OP_QUERY, SLOT_W'(2), coord_t'(1), coord_t'(0));
        send_item(OP_QUERY, SLOT_W'(3), C_MIN, C_MIN);
        send_item(OP_QUERY, SLOT_W'(6), C_MAX, C_MAX);
        send_item(OP_QUERY, SLOT_W'(1), C_MIN, coord_t'(0));
        send_item(OP_QUERY, SLOT_W'(4), coord_t'(-16384), coord_t'(16384));
        send_item(OP_QUERY, SLOT_W'(7), coord_t'(16384), coord_t'(16384));
        send_item(OP_QUERY, SLOT_W'(0), coord_t'(16), C_MAX);
        wait_idle();
    endtask

    // no edges, degenerate edges, clipped count and the smallest real polygon
    task automatic test_count_limits;
        set_vertex_count(CFG_W'(0));
        send_item(OP_QUERY, SLOT_W'(0), coord_t'(0), coord_t'(-16));
        wait_idle();
        set_vertex_count(CFG_W'(2));
        send_item(OP_QUERY, SLOT_W'(3), coord_t'(0), coord_t'(-16));
        wait_idle();
        set_vertex_count({CFG_W{1'b1}});
        send_item(OP_QUERY, SLOT_W'(5), coord_t'(50), coord_t'(-100));
        send_item(OP_QUERY, SLOT_W'(6), coord_t'(0), coord_t'(16));
        wait_idle();
        set_vertex_count(CFG_W'(3));
        send_item(OP_QUERY, SLOT_W'(2), coord_t'(16384), coord_t'(-16384));
        wait_idle();
    endtask

    task automatic test_random_polygons;
        logic [CFG_W-1:0]  counts [$];
        logic [SLOT_W-1:0] slot;
        int                spans [4];
        int                span;
        int                cx;
        int                cy;
        int                k;
        int                v;
        coord_t            qx;
        coord_t            qy;
        counts = '{CFG_W'(3), CFG_W'(8), CFG_W'(4), CFG_W'(15), CFG_W'(5), CFG_W'(0),
                   CFG_W'(7), CFG_W'(9), CFG_W'(6), CFG_W'(1), CFG_W'(2),
                   CFG_W'($urandom_range(0, 15))};
        spans = '{8, 64, 1024, COORD_MAX_I};
        foreach (counts[p])
        begin
            set_vertex_count(counts[p]);
            span = spans[$urandom_range(0, 3)];
            cx   = int'($urandom_range(0, 2 * COORD_MAX_I + 1)) + COORD_MIN_I;
            cy   = int'($urandom_range(0, 2 * COORD_MAX_I + 1)) + COORD_MIN_I;
            if ($urandom_range(0, 3) != 0)
                for (v = 0; v < MAX_VERTICES; v++)
                    send_item(OP_LOAD, SLOT_W'(v), draw_coord(cx, span), draw_coord(cy, span));
            repeat (PHASE_ITEMS)
            begin
                slot = SLOT_W'($urandom_range(0, MAX_VERTICES - 1));
                if ($urandom_range(0, 4) == 0)
                    send_item(OP_LOAD, slot, draw_coord(cx, span), draw_coord(cy, span));
                else
                begin
                    k  = $urandom_range(0, MAX_VERTICES - 1);
                    qx = draw_coord(cx, span);
                    qy = draw_coord(cy, span);
                    // points level with a vertex or on one hit the straddle boundaries
                    case ($urandom_range(0, 5))
                        0: qy = vy_table[k];
                        1: qx = vx_table[k];
                        2:
                        begin
                            qx = vx_table[k];
                            qy = vy_table[k];
                        end
                        default: ;
                    endcase
                    send_item(OP_QUERY, slot, qx, qy);
                end
            end
            wait_idle();
        end
    endtask

    initial
    begin : result_monitor
        int stall;
        bit want;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                sink_steady = ~sink_steady;
            stall = draw_wait(sink_steady);
            if (stall > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
            if (inside_expected.size() == 0)
            begin
                $display("%0t: inside_res transfer with none expected, actual %0b",
                         $time, result_ch.inside_res);
                mismatch_count++;
            end
            else
            begin
                want = inside_expected.pop_front();
                if (result_ch.inside_res !== want)
                    report_mismatch("inside_res", longint'(want), longint'(result_ch.inside_res));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
                (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        mismatch_count        = 0;
        src_steady            = 1'b0;
        sink_steady           = 1'b0;
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        item_ch.valid        <= 1'b0;
        item_ch.op           <= OP_LOAD;
        item_ch.vertex_index <= '0;
        item_ch.coord_x      <= '0;
        item_ch.coord_y      <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_value();
        test_directed_polygon();
        test_count_limits();
        test_random_polygons();
        wait_idle();

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
design/pip_pkg.sv
design/pip_if.sv
design/point_in_polygon_test_top.sv
sim/tb.sv
